FILE: hw/rtl/iae_pkg.sv
// Shared types and constants for the infix expression evaluator.
// Used by iae_ctrl, iae_dpath and infix_arith_expression_evaluator; no dependencies.
package iae_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int VALUE_W       = 32;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPLY,
    ST_RUN,
    ST_POST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } chr_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      div_zero;
  } res_t;

  typedef struct packed {
    logic capture;
    logic digit;
    logic apply_add;
    logic unit_start;
    logic unit_commit;
    logic load_op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic last;
    logic pend_mul;
    logic unit_done;
    logic out_busy;
  } status_t;

endpackage

FILE: hw/rtl/infix_arith_expression_evaluator.sv
// Infix expression evaluator, one character per beat, result after the last beat.
// A digit or ignored character passes through IDLE and DECODE; an operator also passes
// through APPLY and POST, and through RUN (bit-serial unit) too when the pending operator is * or /.
// A last character adds one more operator pass and then EMIT into the result register,
// which waits while an earlier result beat is still untaken.
// Synchronous active-high reset clears the expression state and the result valid flag.
module infix_arith_expression_evaluator import iae_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic chr_valid,
  output logic chr_ready,
  input  chr_t chr,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  cmd_t    cmd;
  status_t status;

  iae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .status    (status),
    .cmd       (cmd)
  );

  iae_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .chr       (chr),
    .cmd       (cmd),
    .status    (status),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // The block handles one character at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (chr_valid && chr_ready) |=> !chr_ready)
    else $error("character accepted while the previous one is in progress");

  // A result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!res_valid || res_ready))
    else $error("result register overwritten");

  // Input stays stalled while the multiplier/divider is running.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.unit_start |=> (!chr_ready && !status.unit_done))
    else $error("input taken or unit finished too early");

endmodule

FILE: hw/rtl/iae_ctrl.sv
// Sequencing state machine of the expression evaluator.
// Depends on iae_pkg; drives the datapath only through cmd_t and reads status_t.
module iae_ctrl import iae_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    chr_valid,
  output logic    chr_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   final_pass, final_pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      final_pass <= 1'b0;
    end else begin
      state      <= state_next;
      final_pass <= final_pass_next;
    end
  end

  always_comb begin
    state_next      = state;
    final_pass_next = final_pass;
    cmd             = '0;
    chr_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        chr_ready   = 1'b1;
        cmd.capture = chr_valid;
        if (chr_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.digit = 1'b1;
        if (status.is_op) begin
          final_pass_next = 1'b0;
          state_next      = ST_APPLY;
        end else if (status.last) begin
          final_pass_next = 1'b1;
          state_next      = ST_APPLY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_APPLY: begin
        if (status.pend_mul) begin
          cmd.unit_start = 1'b1;
          state_next     = ST_RUN;
        end else begin
          cmd.apply_add = 1'b1;
          state_next    = ST_POST;
        end
      end
      ST_RUN: begin
        if (status.unit_done) begin
          cmd.unit_commit = 1'b1;
          state_next      = ST_POST;
        end
      end
      ST_POST: begin
        if (final_pass) begin
          state_next = ST_EMIT;
        end else begin
          cmd.load_op = 1'b1;
          if (status.last) begin
            final_pass_next = 1'b1;
            state_next      = ST_APPLY;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/iae_dpath.sv
// Datapath of the expression evaluator: expression state, shared shift-add
// multiplier / restoring divider, and the result register. Depends on iae_pkg.
module iae_dpath import iae_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  chr_t    chr,
  input  cmd_t    cmd,
  output status_t status,
  input  logic    res_ready,
  output logic    res_valid,
  output res_t    res
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [7:0]       char_q;
  logic             last_q;
  logic [WIDTH-1:0] term_sum, cur_term, num_acc;
  op_t              pend_op;
  logic             err_seen;

  // Shared iterative unit: ua is multiplicand or dividend/quotient, ub the
  // multiplier or divisor magnitude, acc the product or partial remainder.
  logic [WIDTH-1:0] ua, ub, acc;
  logic [CNT_W-1:0] cnt;
  logic             busy, is_div, neg_q, zero_q;

  logic             is_digit, is_op;
  logic [WIDTH-1:0] digit_val, num_next, cur_neg, num_neg, unit_res;
  logic [WIDTH:0]   rem_sh, rem_diff;
  logic [WIDTH-1:0] sum_all;
  op_t              op_code;

  assign is_digit  = (char_q >= CH_0) && (char_q <= CH_9);
  assign is_op     = (char_q == CH_PLUS) || (char_q == CH_MINUS) ||
                     (char_q == CH_TIMES) || (char_q == CH_DIV);
  assign digit_val = WIDTH'(char_q[3:0]);
  assign num_next  = (num_acc << 3) + (num_acc << 1) + digit_val;
  assign cur_neg   = cur_term[WIDTH-1] ? (~cur_term + 1'b1) : cur_term;
  assign num_neg   = num_acc[WIDTH-1]  ? (~num_acc + 1'b1)  : num_acc;
  assign rem_sh    = {acc, ua[WIDTH-1]};
  assign rem_diff  = rem_sh - {1'b0, ub};
  assign sum_all   = term_sum + cur_term;

  always_comb begin
    if (!is_div)     unit_res = acc;
    else if (zero_q) unit_res = '0;
    else if (neg_q)  unit_res = ~ua + 1'b1;
    else             unit_res = ua;
  end

  always_comb begin
    case (char_q)
      CH_PLUS:  op_code = OP_PLUS;
      CH_MINUS: op_code = OP_MINUS;
      CH_TIMES: op_code = OP_TIMES;
      default:  op_code = OP_DIVIDE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q <= chr.char_code;
      last_q <= chr.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      term_sum <= '0;
      cur_term <= '0;
      num_acc  <= '0;
      pend_op  <= OP_PLUS;
      err_seen <= 1'b0;
    end else begin
      if (cmd.digit && is_digit) num_acc <= num_next;
      if (cmd.apply_add) begin
        term_sum <= sum_all;
        cur_term <= (pend_op == OP_MINUS) ? (~num_acc + 1'b1) : num_acc;
        num_acc  <= '0;
      end
      if (cmd.unit_commit) begin
        cur_term <= unit_res;
        num_acc  <= '0;
        if (is_div && zero_q) err_seen <= 1'b1;
      end
      if (cmd.load_op) pend_op <= op_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.unit_start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(WIDTH);
    end else if (cmd.unit_commit) begin
      busy <= 1'b0;
    end else if (busy && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.unit_start) begin
      is_div <= (pend_op == OP_DIVIDE);
      acc    <= '0;
      if (pend_op == OP_DIVIDE) begin
        ua     <= cur_neg;
        ub     <= num_neg;
        neg_q  <= cur_term[WIDTH-1] ^ num_acc[WIDTH-1];
        zero_q <= (num_acc == '0);
      end else begin
        ua <= cur_term;
        ub <= num_acc;
      end
    end else if (busy && (cnt != '0)) begin
      if (is_div) begin
        if (!rem_diff[WIDTH]) begin
          acc <= rem_diff[WIDTH-1:0];
          ua  <= {ua[WIDTH-2:0], 1'b1};
        end else begin
          acc <= rem_sh[WIDTH-1:0];
          ua  <= {ua[WIDTH-2:0], 1'b0};
        end
      end else begin
        if (ub[0]) acc <= acc + ua;
        ua <= ua << 1;
        ub <= ub >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.value    <= VALUE_W'($signed(sum_all));
      res.div_zero <= err_seen;
    end
  end

  assign status.is_op     = is_op;
  assign status.last      = last_q;
  assign status.pend_mul  = (pend_op == OP_TIMES) || (pend_op == OP_DIVIDE);
  assign status.unit_done = busy && (cnt == '0);
  assign status.out_busy  = res_valid && !res_ready;

endmodule

FILE: tb/tb_infix_arith_expression_evaluator.sv
`timescale 1ns / 1ps
// Self-checking testbench for infix_arith_expression_evaluator: directed expressions,
// then random ones, checked beat by beat against an expression evaluator kept here.
// Depends on iae_pkg and the evaluator RTL only.
module tb_infix_arith_expression_evaluator;
  import iae_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int EVAL_W       = DEFAULT_WIDTH;
  localparam int RANDOM_ITEMS = 1540;
  localparam int CALM_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    chr_t beat;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic chr_valid;
  logic chr_ready;
  chr_t chr;
  logic res_valid;
  logic res_ready;
  res_t res;

  // Expression state of the evaluator model.
  logic [EVAL_W-1:0] sum_acc;
  logic [EVAL_W-1:0] term_acc;
  logic [EVAL_W-1:0] num_acc;
  op_t               op_pend;
  logic              dz_flag;

  res_t      expr_results_q[$];
  stim_row_t directed_rows[$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;

  infix_arith_expression_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit is_active(logic [7:0] ch);
    return (ch >= CH_0 && ch <= CH_9) || ch == CH_PLUS || ch == CH_MINUS ||
           ch == CH_TIMES || ch == CH_DIV;
  endfunction

  function automatic void clear_eval();
    sum_acc  = '0;
    term_acc = '0;
    num_acc  = '0;
    op_pend  = OP_PLUS;
    dz_flag  = 1'b0;
  endfunction

  // Signed division on magnitudes, so that the most negative value over minus one
  // wraps instead of overflowing the simulator's own division.
  function automatic logic [EVAL_W-1:0] trunc_div(logic [EVAL_W-1:0] a, logic [EVAL_W-1:0] b);
    logic [EVAL_W-1:0] ma;
    logic [EVAL_W-1:0] mb;
    logic [EVAL_W-1:0] q;
    ma = a[EVAL_W-1] ? -a : a;
    mb = b[EVAL_W-1] ? -b : b;
    if (mb == '0) begin
      dz_flag = 1'b1;
      return '0;
    end
    q = ma / mb;
    return (a[EVAL_W-1] ^ b[EVAL_W-1]) ? -q : q;
  endfunction

  function automatic void fold_number();
    case (op_pend)
      OP_PLUS: begin
        sum_acc  = sum_acc + term_acc;
        term_acc = num_acc;
      end
      OP_MINUS: begin
        sum_acc  = sum_acc + term_acc;
        term_acc = -num_acc;
      end
      OP_TIMES: term_acc = term_acc * num_acc;
      default:  term_acc = trunc_div(term_acc, num_acc);
    endcase
    num_acc = '0;
  endfunction

  function automatic void eval_char(input chr_t c, output bit emitted, output res_t r);
    logic [EVAL_W-1:0] total;
    emitted = 1'b0;
    r = '0;
    if (c.char_code >= CH_0 && c.char_code <= CH_9) begin
      num_acc = num_acc * 10 + (c.char_code - CH_0);
    end else if (is_active(c.char_code)) begin
      fold_number();
      case (c.char_code)
        CH_PLUS:  op_pend = OP_PLUS;
        CH_MINUS: op_pend = OP_MINUS;
        CH_TIMES: op_pend = OP_TIMES;
        default:  op_pend = OP_DIVIDE;
      endcase
    end
    if (c.last_char) begin
      fold_number();
      total      = sum_acc + term_acc;
      r.value    = $signed(total);
      r.div_zero = dz_flag;
      emitted    = 1'b1;
      clear_eval();
    end
  endfunction

  function automatic void add_beat(logic [7:0] ch, bit close, res_t want);
    stim_row_t row;
    row.beat  = {ch, close};
    row.typed = close;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_text(string s, bit close, res_t want);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(s[i], close && (i == s.len() - 1), want);
    end
  endfunction

  function automatic logic [7:0] op_char(int idx);
    case (idx)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      default: return CH_DIV;
    endcase
  endfunction

  // Mostly spaces, sometimes any code the block must ignore.
  function automatic logic [7:0] filler_char();
    logic [7:0] ch;
    if ($urandom_range(0, 9) < 7) return 8'h20;
    do ch = 8'($urandom_range(0, 255)); while (is_active(ch));
    return ch;
  endfunction

  task automatic make_expression(output chr_t beats[$]);
    int         n_terms;
    int         n_digits;
    bit         zero_num;
    logic [7:0] ch;
    beats = {};
    if ($urandom_range(0, 6) == 0) begin
      // Noise: arbitrary codes with digits and operators in no particular order.
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 2))
          0:       ch = op_char($urandom_range(0, 3));
          1:       ch = CH_0 + 8'($urandom_range(0, 9));
          default: ch = 8'($urandom_range(0, 255));
        endcase
        beats.insert(beats.size(), {ch, 1'b0});
      end
    end else begin
      n_terms = $urandom_range(1, 6);
      if ($urandom_range(0, 11) == 0) begin
        beats.insert(beats.size(), {op_char($urandom_range(0, 3)), 1'b0});
      end
      for (int t = 0; t < n_terms; t++) begin
        if (t != 0) begin
          if ($urandom_range(0, 3) == 0) beats.insert(beats.size(), {filler_char(), 1'b0});
          beats.insert(beats.size(), {op_char($urandom_range(0, 3)), 1'b0});
          if ($urandom_range(0, 11) == 0) begin
            beats.insert(beats.size(), {op_char($urandom_range(0, 3)), 1'b0});
          end
          if ($urandom_range(0, 3) == 0) beats.insert(beats.size(), {filler_char(), 1'b0});
        end
        zero_num = ($urandom_range(0, 5) == 0);
        n_digits = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 3);
        if (zero_num) n_digits = $urandom_range(1, 2);
        for (int d = 0; d < n_digits; d++) begin
          ch = zero_num ? CH_0 : CH_0 + 8'($urandom_range(0, 9));
          beats.insert(beats.size(), {ch, 1'b0});
          if ($urandom_range(0, 15) == 0) beats.insert(beats.size(), {filler_char(), 1'b0});
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        beats.insert(beats.size(), {op_char($urandom_range(0, 3)), 1'b0});
      end
    end
    beats[beats.size() - 1].last_char = 1'b1;
  endtask

  task automatic send_beat(input chr_t c, input bit typed, input res_t want);
    bit   emitted;
    res_t r;
    chr       <= c;
    chr_valid <= 1'b1;
    do @(posedge clk); while (!chr_ready);
    eval_char(c, emitted, r);
    if (emitted) expr_results_q.insert(expr_results_q.size(), typed ? want : r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      chr_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    chr_valid <= 1'b0;
    @(posedge clk);
    while (expr_results_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    chr_t beats[$];
    int   sent_items;
    bit   drained_mid;
    sent_items  = 0;
    drained_mid = 1'b0;
    rst       <= 1'b1;
    chr_valid <= 1'b0;
    chr       <= '0;
    clear_eval();

    add_text(" ", 1'b1, {32'd0, 1'b0});
    add_text("/", 1'b1, {32'd0, 1'b1});
    add_text("-2147483648/4294967295", 1'b1, {32'h8000_0000, 1'b0});
    add_beat(8'h00, 1'b0, '0);
    add_text("9*9", 1'b0, '0);
    add_beat(8'hFF, 1'b0, '0);
    add_text("+10", 1'b1, {32'd91, 1'b0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      sent_items++;
    end
    drain_results();

    while (sent_items < RANDOM_ITEMS) begin
      make_expression(beats);
      foreach (beats[i]) begin
        send_beat(beats[i], 1'b0, '0);
        sent_items++;
      end
      if (!drained_mid && sent_items >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      if (sent_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
    end

    chr_valid <= 1'b0;
    while (expr_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_infix_arith_expression_evaluator OK");
    end else begin
      $display("tb_infix_arith_expression_evaluator NOT OK");
    end
    $finish;
  end

  initial begin : result_sink
    forever begin
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // Values are read just after the edge, before any update from that edge lands.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expr_results_q.size() == 0) begin
        $display("%0t: result beat with none expected, actual value %0d div_zero %0b",
                 $time, res.value, res.div_zero);
        errors++;
      end else begin
        want = expr_results_q.pop_front();
        if (res.value !== want.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, want.value, res.value);
          errors++;
        end
        if (res.div_zero !== want.div_zero) begin
          $display("%0t: div_zero mismatch, expected %0b, actual %0b",
                   $time, want.div_zero, res.div_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expr_results_q.size());
      $display("tb_infix_arith_expression_evaluator NOT OK");
      $finish;
    end
  end

endmodule
